// File: rtl/core/bbdf_pkg.sv
// shared types, widths and constants for the detection box decode filter
`default_nettype none

package bbdf_pkg;

  // fixed-point formats
  localparam int FRAC_BITS  = 16;
  localparam int PIXEL_BITS = 13;
  localparam int COORD_W    = FRAC_BITS + 2;
  localparam int SCORE_W    = FRAC_BITS + 1;
  // doubled corner edge, clamped to [0, 2*one]
  localparam int EDGE_W     = FRAC_BITS + 2;
  // 2*center +/- size before clamping
  localparam int SUM_W      = COORD_W + 2;
  localparam int PROD_W     = EDGE_W + PIXEL_BITS;

  // stream payload widths
  localparam int IN_FIELDS_W  = 4 * COORD_W + SCORE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 * PIXEL_BITS + SCORE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 3;

  // configuration port
  localparam int NUM_CFG    = 5;
  localparam int CFG_ADDR_W = $clog2(NUM_CFG);
  localparam int CFG_DATA_W = (SCORE_W > PIXEL_BITS) ? SCORE_W : PIXEL_BITS;

  localparam logic [CFG_ADDR_W-1:0] CFG_SCORE_THRESHOLD = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH     = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT    = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_BOX_SIZE    = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BOX_SIZE    = CFG_ADDR_W'(4);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [SCORE_W-1:0]        score_t;
  typedef logic [PIXEL_BITS-1:0]     pix_t;
  typedef logic [EDGE_W-1:0]         edge_t;

  // register reset values
  localparam score_t RST_SCORE_THRESHOLD = score_t'(32768);
  localparam pix_t   RST_FRAME_WIDTH     = pix_t'(640);
  localparam pix_t   RST_FRAME_HEIGHT    = pix_t'(640);
  localparam pix_t   RST_MIN_BOX_SIZE    = pix_t'(19);
  localparam pix_t   RST_MAX_BOX_SIZE    = pix_t'(512);

  typedef enum logic [1:0] {
    CAUSE_KEEP  = 2'd0,
    CAUSE_SCORE = 2'd1,
    CAUSE_COORD = 2'd2,
    CAUSE_SIZE  = 2'd3
  } cause_t;

  typedef struct packed {
    score_t score_threshold;
    pix_t   frame_width;
    pix_t   frame_height;
    pix_t   min_box_size;
    pix_t   max_box_size;
  } cfg_t;

  // after edge decode
  typedef struct packed {
    cause_t cause;
    edge_t  x1;
    edge_t  x2;
    edge_t  y1;
    edge_t  y2;
    score_t score;
  } dec_t;

  // after scaling to pixels
  typedef struct packed {
    cause_t cause;
    pix_t   x1;
    pix_t   x2;
    pix_t   y1;
    pix_t   y2;
    score_t score;
  } pbox_t;

  // final result item
  typedef struct packed {
    logic   keep;
    cause_t cause;
    pix_t   left_px;
    pix_t   top_px;
    pix_t   width_px;
    pix_t   height_px;
    score_t score_out;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/bbdf_decode.sv
// score and coordinate checks, doubled corner edges with clamping
`default_nettype none

module bbdf_decode (
  input  bbdf_pkg::coord_t     center_x,
  input  bbdf_pkg::coord_t     center_y,
  input  bbdf_pkg::coord_t     box_w,
  input  bbdf_pkg::coord_t     box_h,
  input  bbdf_pkg::score_t     score,
  input  bbdf_pkg::score_t     score_threshold,
  output bbdf_pkg::dec_t       dec
);
  import bbdf_pkg::*;

  localparam coord_t FIX_ONE = coord_t'(2 ** FRAC_BITS);
  localparam sum_t   TWO_ONE = sum_t'(2 ** (FRAC_BITS + 1));

  logic coord_bad;
  sum_t cx2, cy2, bw_s, bh_s;

  function automatic edge_t clamp_edge(input sum_t e);
    edge_t r;
    if (e < 0) begin
      r = '0;
    end else if (e > TWO_ONE) begin
      r = edge_t'(TWO_ONE);
    end else begin
      r = edge_t'(e);
    end
    return r;
  endfunction

  // range checks on center and size
  always_comb begin
    coord_bad = (center_x < 0) || (center_x > FIX_ONE) ||
                (center_y < 0) || (center_y > FIX_ONE) ||
                (box_w <= 0) || (box_w > FIX_ONE) ||
                (box_h <= 0) || (box_h > FIX_ONE);
  end

  // doubled edges: 2*center -/+ size
  assign cx2  = sum_t'(center_x) <<< 1;
  assign cy2  = sum_t'(center_y) <<< 1;
  assign bw_s = sum_t'(box_w);
  assign bh_s = sum_t'(box_h);

  always_comb begin
    dec.x1    = clamp_edge(cx2 - bw_s);
    dec.x2    = clamp_edge(cx2 + bw_s);
    dec.y1    = clamp_edge(cy2 - bh_s);
    dec.y2    = clamp_edge(cy2 + bh_s);
    dec.score = score;
    if (score < score_threshold) begin
      dec.cause = CAUSE_SCORE;
    end else if (coord_bad) begin
      dec.cause = CAUSE_COORD;
    end else begin
      dec.cause = CAUSE_KEEP;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bbdf_scale.sv
// scale clamped edges by the frame size and truncate to pixels
`default_nettype none

module bbdf_scale (
  input  bbdf_pkg::dec_t       dec,
  input  bbdf_pkg::pix_t       frame_width,
  input  bbdf_pkg::pix_t       frame_height,
  output bbdf_pkg::pbox_t      pbox
);
  import bbdf_pkg::*;

  // floor(edge2 * dim / 2^(F+1)); result always fits the pixel width
  function automatic pix_t to_pixels(input edge_t e, input pix_t dim);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(e) * PROD_W'(dim);
    return prod[FRAC_BITS+1 +: PIXEL_BITS];
  endfunction

  always_comb begin
    pbox.cause = dec.cause;
    pbox.x1    = to_pixels(dec.x1, frame_width);
    pbox.x2    = to_pixels(dec.x2, frame_width);
    pbox.y1    = to_pixels(dec.y1, frame_height);
    pbox.y2    = to_pixels(dec.y2, frame_height);
    pbox.score = dec.score;
  end

endmodule

`default_nettype wire

// File: rtl/core/bbdf_filter.sv
// final stage: pixel size check, final cause and result register
`default_nettype none

module bbdf_filter (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  pbox_valid,
  input  bbdf_pkg::pbox_t      pbox,
  input  bbdf_pkg::pix_t       min_box_size,
  input  bbdf_pkg::pix_t       max_box_size,
  output logic                 res_valid_r,
  output bbdf_pkg::res_t       res_r
);
  import bbdf_pkg::*;

  res_t   res_nxt;
  pix_t   w_px, h_px;
  logic   size_bad;
  cause_t cause;

  // corners of items that pass the coordinate check are ordered, so their differences never go negative
  assign w_px = pbox.x2 - pbox.x1;
  assign h_px = pbox.y2 - pbox.y1;

  always_comb begin
    size_bad = (w_px < min_box_size) || (h_px < min_box_size) ||
               (w_px > max_box_size) || (h_px > max_box_size);
    if (pbox.cause != CAUSE_KEEP) begin
      cause = pbox.cause;
    end else if (size_bad) begin
      cause = CAUSE_SIZE;
    end else begin
      cause = CAUSE_KEEP;
    end
  end

  // rejected boxes carry zero geometry
  always_comb begin
    res_nxt.keep      = (cause == CAUSE_KEEP);
    res_nxt.cause     = cause;
    res_nxt.score_out = pbox.score;
    if (cause == CAUSE_KEEP) begin
      res_nxt.left_px   = pbox.x1;
      res_nxt.top_px    = pbox.y1;
      res_nxt.width_px  = w_px;
      res_nxt.height_px = h_px;
    end else begin
      res_nxt.left_px   = '0;
      res_nxt.top_px    = '0;
      res_nxt.width_px  = '0;
      res_nxt.height_px = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= pbox_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/detection_box_decode_filter.sv
// top level: input register, decode and scale logic, result register, config
// an accepted item passes from the input register into the result register
// throughput: one item per cycle while out_tready holds; the input register
// advances when it is empty or the result register is empty or being read,
// so bubbles collapse; rst_n (synchronous, active low) empties both
// registers and loads the config registers with their defaults
`default_nettype none

module detection_box_decode_filter (
  input  wire                                clk,
  input  wire                                rst_n,
  // in_tdata: center_x, center_y, box_w, box_h, score (lowest bit first)
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [bbdf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: left_px, top_px, width_px, height_px, score_out
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [bbdf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: keep, reject_cause
  output logic [bbdf_pkg::OUT_TUSER_W-1:0]   out_tuser,
  // config write port
  input  wire                                cfg_we,
  input  wire  [bbdf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire  [bbdf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bbdf_pkg::*;

  cfg_t   cfg_r;
  logic   in_valid_r;
  coord_t cx_r, cy_r, bw_r, bh_r;
  score_t score_r;

  dec_t   dec;
  pbox_t  pbox;
  res_t   res;

  logic   en0, en1;

  // register enables
  assign en1       = !out_tvalid || out_tready;
  assign en0       = !in_valid_r || en1;
  assign in_tready = en0;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.score_threshold <= RST_SCORE_THRESHOLD;
      cfg_r.frame_width     <= RST_FRAME_WIDTH;
      cfg_r.frame_height    <= RST_FRAME_HEIGHT;
      cfg_r.min_box_size    <= RST_MIN_BOX_SIZE;
      cfg_r.max_box_size    <= RST_MAX_BOX_SIZE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCORE_THRESHOLD: cfg_r.score_threshold <= cfg_wdata[SCORE_W-1:0];
        CFG_FRAME_WIDTH:     cfg_r.frame_width     <= cfg_wdata[PIXEL_BITS-1:0];
        CFG_FRAME_HEIGHT:    cfg_r.frame_height    <= cfg_wdata[PIXEL_BITS-1:0];
        CFG_MIN_BOX_SIZE:    cfg_r.min_box_size    <= cfg_wdata[PIXEL_BITS-1:0];
        CFG_MAX_BOX_SIZE:    cfg_r.max_box_size    <= cfg_wdata[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en0) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      cx_r    <= in_tdata[0*COORD_W +: COORD_W];
      cy_r    <= in_tdata[1*COORD_W +: COORD_W];
      bw_r    <= in_tdata[2*COORD_W +: COORD_W];
      bh_r    <= in_tdata[3*COORD_W +: COORD_W];
      score_r <= in_tdata[4*COORD_W +: SCORE_W];
    end
  end

  bbdf_decode u_decode (
    .center_x        (cx_r),
    .center_y        (cy_r),
    .box_w           (bw_r),
    .box_h           (bh_r),
    .score           (score_r),
    .score_threshold (cfg_r.score_threshold),
    .dec             (dec)
  );

  bbdf_scale u_scale (
    .dec          (dec),
    .frame_width  (cfg_r.frame_width),
    .frame_height (cfg_r.frame_height),
    .pbox         (pbox)
  );

  bbdf_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en1),
    .pbox_valid   (in_valid_r),
    .pbox         (pbox),
    .min_box_size (cfg_r.min_box_size),
    .max_box_size (cfg_r.max_box_size),
    .res_valid_r  (out_tvalid),
    .res_r        (res)
  );

  // result packing
  assign out_tdata = OUT_TDATA_W'({res.score_out, res.height_px, res.width_px,
                                   res.top_px, res.left_px});
  assign out_tuser = {res.cause, res.keep};

endmodule

`default_nettype wire

// File: rtl/core/bbdf_checker.sv
// port-level checks on the result stream, bound to the top level
`default_nettype none

module bbdf_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tready,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [bbdf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire [bbdf_pkg::OUT_TUSER_W-1:0]    out_tuser
);
  import bbdf_pkg::*;

  localparam int GEOM_W = 4 * PIXEL_BITS;

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // keep flag agrees with the reject cause
  a_keep_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tuser[2:1] == CAUSE_KEEP)))
    else $error("keep flag disagrees with reject cause");

  // rejected items carry no geometry
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[GEOM_W-1:0] == '0))
    else $error("rejected item has nonzero box");

  // input is always taken while the output drains
  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind detection_box_decode_filter bbdf_checker u_bbdf_checker (.*);

`default_nettype wire
